// ----- rtl/ebs_pkg.sv -----
package ebs_pkg;

    // Sizing
    localparam int MAX_MEMBERS = 256;
    localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
    localparam int DATA_W      = 32;
    localparam int SPAN_W      = 32;

    // Gringorten plotting position scaled by 100: (100k - 44) / (100n + 12)
    localparam int GRING_SCALE = 100;
    localparam int GRING_NUM   = 56;   // 100 - 44, offset of the exceedance numerator
    localparam int GRING_DEN   = 12;
    localparam int COEF_W      = $clog2(GRING_SCALE * MAX_MEMBERS + GRING_NUM + 1);
    localparam int PROD_W      = COEF_W + SPAN_W;
    localparam int OFFS_W      = SPAN_W + $clog2(GRING_SCALE + 1);

    // Result formats
    localparam int Q_W         = 16;
    localparam int SCORE_W     = Q_W + 1;
    localparam int SQ_W        = 2 * SCORE_W;
    localparam int STATUS_W    = 2;
    localparam int DIV_STEPS   = Q_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [SCORE_W-1:0] PROB_ONE = SCORE_W'(1 << Q_W);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_VALID       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALL_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW     = 2'd2;

    // Probability source
    localparam logic [1:0] PM_CALC = 2'd0;
    localparam logic [1:0] PM_ONE  = 2'd1;
    localparam logic [1:0] PM_ZERO = 2'd2;

    typedef struct packed {
        logic acc_en;
        logic prep;
        logic mul;
        logic sub;
        logic div_step;
        logic rnd;
        logic sq;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/ebs_ctrl.sv -----
module ebs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  ebs_pkg::t_stat i_stat,
    output ebs_pkg::t_cmd  o_cmd
);
    import ebs_pkg::*;

    localparam logic [2:0] S_ACC  = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUB  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_RND  = 3'd5;
    localparam logic [2:0] S_SQ   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              accept;

    assign o_in_ready = (r_state == S_ACC);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_ACC: begin
                o_cmd.acc_en = accept;
                if (accept && i_in_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_step    = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_RND;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTH
    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |=> !o_in_ready)
        else $error("input still ready after the last member");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("result loaded over an untaken result");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == STEP_W'(DIV_STEPS - 1)) |=> (r_state == S_RND))
        else $error("division did not end after its last step");

    a_load_resumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (o_in_ready && !o_cmd.load_out))
        else $error("input not reopened after result load");
`endif

endmodule

// ----- rtl/ebs_datapath.sv -----
module ebs_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic signed [ebs_pkg::DATA_W-1:0] i_cfg_wdata,
    input  logic signed [ebs_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_missing,
    input  logic signed [ebs_pkg::DATA_W-1:0] i_observed,
    input  ebs_pkg::t_cmd                     i_cmd,
    output ebs_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ebs_pkg::SCORE_W-1:0]       o_score,
    output logic [ebs_pkg::STATUS_W-1:0]      o_status
);
    import ebs_pkg::*;

    // accumulated ensemble summary
    logic signed [DATA_W-1:0] r_threshold;
    logic [CNT_W-1:0]         r_n, r_k;
    logic signed [DATA_W-1:0] r_lo, r_hi;
    logic                     r_obs_hit;

    // computation
    logic [1:0]          r_mode;
    logic [STATUS_W-1:0] r_status;
    logic [COEF_W-1:0]   r_coef_a, r_coef_b;
    logic [SPAN_W-1:0]   r_span, r_offs;
    logic [PROD_W-1:0]   r_prod_a, r_prod_b;
    logic [OFFS_W-1:0]   r_prod_o;
    logic [PROD_W-1:0]   r_rem, r_den;
    logic [Q_W-1:0]      r_quo;
    logic [SCORE_W-1:0]  r_prob;
    logic [SQ_W-1:0]     r_sq;

    // output register
    logic                r_out_valid;
    logic [SCORE_W-1:0]  r_out_score;
    logic [STATUS_W-1:0] r_out_status;

    logic                     take;
    logic                     le_t;
    logic [CNT_W-1:0]         n_minus_k;
    logic [COEF_W-1:0]        coef_base;
    logic signed [DATA_W:0]   span_full, offs_full;
    logic [PROD_W:0]          rem_shift, den_ext;
    logic [SCORE_W-1:0]       mag;
    logic [SQ_W:0]            sq_round;

    assign take      = i_cmd.acc_en && !i_missing && (r_n < CNT_W'(MAX_MEMBERS));
    assign le_t      = (i_sample <= r_threshold);
    assign n_minus_k = r_n - r_k;
    assign coef_base = COEF_W'(n_minus_k) * COEF_W'(GRING_SCALE) + COEF_W'(GRING_NUM);
    assign span_full = {r_hi[DATA_W-1], r_hi} - {r_lo[DATA_W-1], r_lo};
    assign offs_full = {r_threshold[DATA_W-1], r_threshold} - {r_lo[DATA_W-1], r_lo};
    assign rem_shift = {r_rem, 1'b0};
    assign den_ext   = {1'b0, r_den};
    assign mag       = r_obs_hit ? (PROB_ONE - r_prob) : r_prob;
    assign sq_round  = {1'b0, r_sq} + (SQ_W + 1)'(1 << (Q_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_wen) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // member classification; clear once the result is handed off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_n  <= '0;
            r_k  <= '0;
            r_lo <= {1'b1, {(DATA_W-1){1'b0}}};
            r_hi <= {1'b0, {(DATA_W-1){1'b1}}};
        end else if (take) begin
            r_n <= r_n + CNT_W'(1);
            if (le_t) begin
                r_k <= r_k + CNT_W'(1);
                if (i_sample > r_lo) begin
                    r_lo <= i_sample;
                end
            end else if (i_sample < r_hi) begin
                r_hi <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            r_obs_hit <= (i_observed >= r_threshold);
        end
    end

    // pick the interpolation case and its coefficients
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            if (r_n == '0) begin
                r_status <= ST_ALL_MISSING;
            end else if (r_n <= CNT_W'(2)) begin
                r_status <= ST_TOO_FEW;
            end else begin
                r_status <= ST_VALID;
            end
            r_coef_b <= COEF_W'(r_n) * COEF_W'(GRING_SCALE) + COEF_W'(GRING_DEN);
            if (r_k == '0) begin
                r_mode   <= PM_ONE;
                r_coef_a <= coef_base;
                r_span   <= SPAN_W'(1);
                r_offs   <= '0;
            end else if (r_k >= r_n) begin
                r_mode   <= (r_threshold > r_lo) ? PM_ZERO : PM_CALC;
                r_coef_a <= coef_base;
                r_span   <= SPAN_W'(1);
                r_offs   <= '0;
            end else if (r_threshold <= r_lo) begin
                r_mode   <= PM_CALC;
                r_coef_a <= coef_base;
                r_span   <= SPAN_W'(1);
                r_offs   <= '0;
            end else if (r_threshold >= r_hi) begin
                r_mode   <= PM_CALC;
                r_coef_a <= coef_base - COEF_W'(GRING_SCALE);
                r_span   <= SPAN_W'(1);
                r_offs   <= '0;
            end else begin
                r_mode   <= PM_CALC;
                r_coef_a <= coef_base;
                r_span   <= span_full[SPAN_W-1:0];
                r_offs   <= offs_full[SPAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_a <= PROD_W'(r_coef_a) * PROD_W'(r_span);
            r_prod_b <= PROD_W'(r_coef_b) * PROD_W'(r_span);
            r_prod_o <= OFFS_W'(r_offs) * OFFS_W'(GRING_SCALE);
        end
    end

    // restoring division, one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.sub) begin
            r_rem <= r_prod_a - PROD_W'(r_prod_o);
            r_den <= r_prod_b;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_shift >= den_ext) begin
                r_rem <= PROD_W'(rem_shift - den_ext);
                r_quo <= {r_quo[Q_W-2:0], 1'b1};
            end else begin
                r_rem <= PROD_W'(rem_shift);
                r_quo <= {r_quo[Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd) begin
            case (r_mode)
                PM_ONE:  r_prob <= PROB_ONE;
                PM_ZERO: r_prob <= '0;
                default: r_prob <= {1'b0, r_quo} + SCORE_W'(rem_shift >= den_ext);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_sq <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_score  <= (r_status == ST_VALID) ? sq_round[Q_W+SCORE_W-1:Q_W] : '0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_score         = r_out_score;
    assign o_status        = r_out_status;

endmodule

// ----- rtl/ensemble_brier_score.sv -----
// Ensemble Brier score with Gringorten plotting positions.
// Slave stream: one ensemble member per transfer. tdata carries sample (low 32 bits)
// and observed (high 32 bits), tuser flags a missing member, tlast closes the
// ensemble; observed is only used on the tlast transfer.
// Master stream: one result per ensemble. tdata carries the 17-bit Q1.16 score,
// tuser the status (0 valid, 1 all members missing, 2 two or fewer members).
// Configuration: i_cfg_wen writes the Q16.16 threshold; write it between
// ensembles or at least before the tlast transfer of the one it applies to.
// Throughput: members transfer one per cycle while s_axis_tready is high. After the
// tlast transfer s_axis_tready drops while the closing pipeline runs (setup,
// multiply, a 16-step restoring divider, round, square), and the result then
// enters the output register.
// A result waiting in the output register does not block the next ensemble's
// members; if a second ensemble closes before the receiver takes the first result,
// the block holds its result and keeps tready low until the output frees up.
// Reset (synchronous, active low) clears the threshold to 0, empties the output
// register and starts a fresh ensemble.
module ensemble_brier_score (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] sample, [63:32] observed
    input  logic        s_axis_tuser,   // [0] missing
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] score, [23:17] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import ebs_pkg::*;

    t_cmd                 cmd;
    t_stat                stat;
    logic [SCORE_W-1:0]   score;
    logic [STATUS_W-1:0]  status;

    // sequencing: accept members, then step the closing pipeline
    ebs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // running summary, probability arithmetic and output register
    ebs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata[31:0]),
        .i_missing   (s_axis_tuser),
        .i_observed  (s_axis_tdata[63:32]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_score     (score),
        .o_status    (status)
    );

    assign m_axis_tdata = {(24 - SCORE_W)'(0), score};
    assign m_axis_tuser = status;

endmodule
